// ===== hdl/string_literal_escaper_unit_macros.svh =====
// Assertion macros shared by the string literal escaper RTL.
`ifndef STRING_LITERAL_ESCAPER_UNIT_MACROS_SVH
`define STRING_LITERAL_ESCAPER_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SLE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SLE_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sle_pkg.sv =====
// Types, codes and the escape function of the string literal escaper.
package sle_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_CODE_POINT  = 2'd0;
    localparam logic [1:0] OP_OPEN_QUOTE  = 2'd1;
    localparam logic [1:0] OP_CLOSE_QUOTE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ASCII_ONLY  = 2'd0;
    localparam logic [1:0] CFG_QUOTE_STYLE = 2'd1;

    // Characters.
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    // Control codes with short escapes.
    localparam logic [7:0] CC_BACKSPACE = 8'h08;
    localparam logic [7:0] CC_TAB       = 8'h09;
    localparam logic [7:0] CC_NEWLINE   = 8'h0A;
    localparam logic [7:0] CC_FORMFEED  = 8'h0C;
    localparam logic [7:0] CC_RETURN    = 8'h0D;

    // Code point boundaries.
    localparam logic [20:0] FIRST_PRINTABLE = 21'h00_0020;
    localparam logic [20:0] LAST_PRINTABLE  = 21'h00_007E;
    localparam logic [20:0] LAST_ASCII      = 21'h00_007F;
    localparam logic [20:0] LAST_TWO_BYTE   = 21'h00_07FF;
    localparam logic [20:0] SURR_FIRST      = 21'h00_D800;
    localparam logic [20:0] SURR_LAST       = 21'h00_DFFF;
    localparam logic [20:0] BYTE_ORDER_MARK = 21'h00_FEFF;
    localparam logic [20:0] BMP_LAST        = 21'h00_FFFF;
    localparam logic [20:0] PLANE_ONE       = 21'h01_0000;
    localparam logic [20:0] UNICODE_LAST    = 21'h10_FFFF;

    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
    localparam logic [15:0] REPLACEMENT    = 16'hFFFD;

    localparam int unsigned MAX_BYTES = 12;

    // Transaction payloads.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [20:0] code_point;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  byte_count;
        logic [63:0] bytes_first_eight;
        logic [31:0] bytes_last_four;
    } out_item_t;

    // Uppercase hex digit of one nibble.
    function automatic logic [7:0] hex_digit(logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = 8'h30 + {4'd0, nib};
        end
        else
        begin
            ch = 8'h37 + {4'd0, nib};
        end
        return ch;
    endfunction

    // Six bytes of a \uXXXX escape, first byte in bits 7:0.
    function automatic logic [47:0] u_escape(logic [15:0] v);
        return {hex_digit(v[3:0]), hex_digit(v[7:4]), hex_digit(v[11:8]),
                hex_digit(v[15:12]), CH_LOWER_U, CH_BACKSLASH};
    endfunction

    // Escapes one input item into its packed result.
    function automatic out_item_t escape_item(in_item_t item, logic ascii_only,
                                              logic quote_style);
        logic [7:0]  b [MAX_BYTES];
        logic [3:0]  n;
        logic [7:0]  quote;
        logic [20:0] cp;
        logic [20:0] d;
        logic [15:0] hi_unit;
        logic [15:0] lo_unit;
        logic [47:0] esc_a;
        logic [47:0] esc_b;
        logic        two_escapes;
        logic        one_escape;
        out_item_t   r;

        for (int i = 0; i < MAX_BYTES; i++)
        begin
            b[i] = 8'h00;
        end
        cp          = item.code_point;
        quote       = quote_style ? CH_SQUOTE : CH_DQUOTE;
        d           = cp - PLANE_ONE;
        hi_unit     = SURR_HIGH_BASE | {6'd0, d[19:10]};
        lo_unit     = SURR_LOW_BASE | {6'd0, d[9:0]};
        esc_a       = u_escape(cp[15:0]);
        esc_b       = u_escape(lo_unit);
        one_escape  = 1'b0;
        two_escapes = 1'b0;
        n           = 4'd1;

        // Pick the form of the item.
        if (item.opcode != OP_CODE_POINT)
        begin
            b[0] = quote;
        end
        else if (cp <= LAST_PRINTABLE)
        begin
            if (cp[7:0] == CH_BACKSLASH || cp[7:0] == quote)
            begin
                b[0] = CH_BACKSLASH;
                b[1] = cp[7:0];
                n    = 4'd2;
            end
            else if (cp >= FIRST_PRINTABLE)
            begin
                b[0] = cp[7:0];
            end
            else
            begin
                b[0] = CH_BACKSLASH;
                n    = 4'd2;
                unique case (cp[7:0])
                    CC_BACKSPACE: b[1] = CH_LOWER_B;
                    CC_FORMFEED:  b[1] = CH_LOWER_F;
                    CC_NEWLINE:   b[1] = CH_LOWER_N;
                    CC_RETURN:    b[1] = CH_LOWER_R;
                    CC_TAB:       b[1] = CH_LOWER_T;
                    default:      one_escape = 1'b1;
                endcase
            end
        end
        else if (cp > UNICODE_LAST)
        begin
            esc_a      = u_escape(REPLACEMENT);
            one_escape = 1'b1;
        end
        else if (!ascii_only && cp != BYTE_ORDER_MARK && (cp < SURR_FIRST || cp > SURR_LAST))
        begin
            // UTF-8 encoding.
            if (cp <= LAST_ASCII)
            begin
                b[0] = cp[7:0];
            end
            else if (cp <= LAST_TWO_BYTE)
            begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
                n    = 4'd2;
            end
            else if (cp <= BMP_LAST)
            begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
                n    = 4'd3;
            end
            else
            begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
                n    = 4'd4;
            end
        end
        else if (cp <= BMP_LAST)
        begin
            one_escape = 1'b1;
        end
        else
        begin
            esc_a       = u_escape(hi_unit);
            two_escapes = 1'b1;
        end

        // Lay out the \u escapes.
        if (one_escape || two_escapes)
        begin
            for (int i = 0; i < 6; i++)
            begin
                b[i] = esc_a[8*i +: 8];
            end
            n = 4'd6;
        end
        if (two_escapes)
        begin
            for (int i = 0; i < 6; i++)
            begin
                b[i+6] = esc_b[8*i +: 8];
            end
            n = 4'd12;
        end

        // Pack the bytes.
        r.byte_count = n;
        for (int i = 0; i < 8; i++)
        begin
            r.bytes_first_eight[8*i +: 8] = b[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            r.bytes_last_four[8*i +: 8] = b[i+8];
        end
        return r;
    endfunction

endpackage

// ===== hdl/string_literal_escaper_unit.sv =====
// String literal escaper top level: input register, escape logic, result register.
// A transaction is held in the input register, then escaped into the result register.
// Throughput: one transaction per cycle while out_stall is low; the escape function between
// the two registers sets the cycle time.
// Reset clears both valid flags and the two configuration registers.
`include "string_literal_escaper_unit_macros.svh"

module string_literal_escaper_unit
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data
);

    logic      ascii_only_reg;
    logic      quote_style_reg;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_data_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    logic      out_load;
    logic      in_take;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascii_only_reg  <= 1'b0;
            quote_style_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_ASCII_ONLY)
            begin
                ascii_only_reg <= cfg_data;
            end
            if (cfg_index == CFG_QUOTE_STYLE)
            begin
                quote_style_reg <= cfg_data;
            end
        end
    end

    // Handshake control: the result register loads when empty or drained.
    always_comb
    begin
        out_load       = !out_valid_reg || !out_stall;
        in_stall       = s1_valid_reg && !out_load;
        in_take        = in_valid && !in_stall;
        s1_valid_next  = in_take ? 1'b1 : (s1_valid_reg && !out_load);
        out_valid_next = out_load ? s1_valid_reg : out_valid_reg;
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (out_load && s1_valid_reg)
        begin
            out_data_reg <= escape_item(s1_data_reg, ascii_only_reg, quote_style_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks on the pipeline and the result layout.
    `SLE_ASSERT(a_count_range, out_valid_reg |-> (out_data_reg.byte_count != 4'd0 && out_data_reg.byte_count <= 4'd12), "byte count out of range")
    `SLE_ASSERT(a_short_upper_zero, (out_valid_reg && out_data_reg.byte_count <= 4'd8) |-> out_data_reg.bytes_last_four == 32'd0, "unused upper bytes not zero")
    `SLE_ASSERT(a_stage_moves, (s1_valid_reg && out_load) |=> out_valid_reg, "input stage transaction lost")
    `SLE_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> (s1_valid_reg && out_valid_reg), "stall without held transactions")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the string literal escaper unit.
module tb_top;
    import sle_pkg::*;

    // Opcode and register indexes that the block does not define.
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam int LONG_HOLD_CYCLES = 60;
    localparam int MAX_REPORTS      = 10;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_wr_en  = 1'b0;
    logic [1:0] cfg_index  = 2'd0;
    logic       cfg_data   = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    in_item_t   in_data    = '0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    out_item_t  out_data;

    // Characters waiting to be sent and escapes waiting to come back.
    in_item_t  unsent_chars [$];
    out_item_t expected_escapes [$];
    out_item_t expected_head;

    // Copy of the configuration as the block holds it.
    logic ascii_only_shadow  = 1'b0;
    logic quote_style_shadow = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_count    = 0;
    logic hold_request = 1'b0;
    int fail_count    = 0;

    string_literal_escaper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Uppercase hex character of one nibble.
    function automatic logic [7:0] nibble_char(logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 8'h30 + 8'(nib);
        end
        return 8'h41 + 8'(nib) - 8'd10;
    endfunction

    // Works out the literal bytes that one character adds under a given setting.
    function automatic out_item_t predict_literal_bytes(in_item_t item, logic ascii_mode,
                                                        logic single_quote);
        logic [7:0]  seq [$];
        logic [15:0] units [$];
        logic [7:0]  quote_ch;
        logic [20:0] cp;
        logic [20:0] offset;
        out_item_t   res;

        res      = '0;
        cp       = item.code_point;
        quote_ch = single_quote ? CH_SQUOTE : CH_DQUOTE;
        if (item.opcode != OP_CODE_POINT)
        begin
            seq = {seq, quote_ch};
        end
        else if (cp <= LAST_PRINTABLE)
        begin
            if (cp == 21'(CH_BACKSLASH) || cp == 21'(quote_ch))
            begin
                seq = {seq, CH_BACKSLASH};
                seq = {seq, cp[7:0]};
            end
            else if (cp >= FIRST_PRINTABLE)
            begin
                seq = {seq, cp[7:0]};
            end
            else
            begin
                case (cp[7:0])
                    CC_BACKSPACE: seq = '{CH_BACKSLASH, CH_LOWER_B};
                    CC_FORMFEED:  seq = '{CH_BACKSLASH, CH_LOWER_F};
                    CC_NEWLINE:   seq = '{CH_BACKSLASH, CH_LOWER_N};
                    CC_RETURN:    seq = '{CH_BACKSLASH, CH_LOWER_R};
                    CC_TAB:       seq = '{CH_BACKSLASH, CH_LOWER_T};
                    default:      units = {units, cp[15:0]};
                endcase
            end
        end
        else if (cp > UNICODE_LAST)
        begin
            units = {units, REPLACEMENT};
        end
        else if (!ascii_mode && cp != BYTE_ORDER_MARK && (cp < SURR_FIRST || cp > SURR_LAST))
        begin
            // Raw UTF-8.
            if (cp < 21'h80)
            begin
                seq = {seq, cp[7:0]};
            end
            else if (cp < 21'h800)
            begin
                seq = {seq, 8'hC0 | 8'(cp >> 6)};
                seq = {seq, 8'h80 | 8'(cp & 21'h3F)};
            end
            else if (cp < 21'h10000)
            begin
                seq = {seq, 8'hE0 | 8'(cp >> 12)};
                seq = {seq, 8'h80 | 8'((cp >> 6) & 21'h3F)};
                seq = {seq, 8'h80 | 8'(cp & 21'h3F)};
            end
            else
            begin
                seq = {seq, 8'hF0 | 8'((cp >> 18) & 21'h7)};
                seq = {seq, 8'h80 | 8'((cp >> 12) & 21'h3F)};
                seq = {seq, 8'h80 | 8'((cp >> 6) & 21'h3F)};
                seq = {seq, 8'h80 | 8'(cp & 21'h3F)};
            end
        end
        else if (cp <= BMP_LAST)
        begin
            units = {units, cp[15:0]};
        end
        else
        begin
            // Supplementary plane: split into a surrogate pair.
            offset = cp - PLANE_ONE;
            units  = {units, 16'hD800 + 16'(offset[19:10])};
            units  = {units, 16'hDC00 + 16'(offset[9:0])};
        end

        foreach (units[k])
        begin
            seq = {seq, CH_BACKSLASH};
            seq = {seq, CH_LOWER_U};
            for (int s = 12; s >= 0; s -= 4)
            begin
                seq = {seq, nibble_char(4'(units[k] >> s))};
            end
        end

        res.byte_count = 4'(seq.size());
        foreach (seq[k])
        begin
            if (k < 8)
            begin
                res.bytes_first_eight[8*k +: 8] = seq[k];
            end
            else
            begin
                res.bytes_last_four[8*(k-8) +: 8] = seq[k];
            end
        end
        return res;
    endfunction

    // Random character, spread over the escape classes.
    function automatic in_item_t random_char();
        in_item_t item;
        int unsigned pick;

        item.opcode     = OP_CODE_POINT;
        item.code_point = 21'($urandom);
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            item.opcode = 2'($urandom_range(1, 3));
        end
        else if (pick < 28)
        begin
            item.code_point = 21'($urandom_range(32, 126));
        end
        else if (pick < 38)
        begin
            case ($urandom_range(2))
                0:       item.code_point = 21'(CH_DQUOTE);
                1:       item.code_point = 21'(CH_SQUOTE);
                default: item.code_point = 21'(CH_BACKSLASH);
            endcase
        end
        else if (pick < 48)
        begin
            item.code_point = ($urandom_range(7) == 0) ? LAST_ASCII
                                                       : 21'($urandom_range(0, 31));
        end
        else if (pick < 62)
        begin
            item.code_point = ($urandom_range(1) == 0) ? 21'($urandom_range(16'h80, 16'h7FF))
                                                       : 21'($urandom_range(16'h800, 16'hFFFF));
        end
        else if (pick < 70)
        begin
            item.code_point = ($urandom_range(4) == 0) ? BYTE_ORDER_MARK
                                                       : 21'($urandom_range(16'hD800, 16'hDFFF));
        end
        else if (pick < 85)
        begin
            item.code_point = 21'($urandom_range(32'h10000, 32'h10FFFF));
        end
        else if (pick < 92)
        begin
            item.code_point = 21'($urandom_range(32'h110000, 32'h1FFFFF));
        end
        return item;
    endfunction

    // Input side: offers queued characters and records what each one should give.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_escapes = {expected_escapes,
                    predict_literal_bytes(in_data, ascii_only_shadow, quote_style_shadow)};
            end
            if (!in_valid || !in_stall)
            begin
                if (unsent_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= unsent_chars.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
        end
        else if (hold_count != 0)
        begin
            hold_count <= hold_count - 1;
        end
        else if (hold_request)
        begin
            hold_count <= LONG_HOLD_CYCLES;
        end
    end

    // Output side: random stall and a field by field check of each transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_escapes.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                    begin
                        $display("unexpected result: count %0d bytes %h %h",
                                 out_data.byte_count, out_data.bytes_last_four,
                                 out_data.bytes_first_eight);
                    end
                    fail_count++;
                end
                else
                begin
                    expected_head = expected_escapes.pop_front();
                    if (out_data.byte_count !== expected_head.byte_count ||
                        out_data.bytes_first_eight !== expected_head.bytes_first_eight ||
                        out_data.bytes_last_four !== expected_head.bytes_last_four)
                    begin
                        if (fail_count < MAX_REPORTS)
                        begin
                            $display("mismatch: expected count %0d bytes %h %h, got %0d %h %h",
                                     expected_head.byte_count, expected_head.bytes_last_four,
                                     expected_head.bytes_first_eight, out_data.byte_count,
                                     out_data.bytes_last_four, out_data.bytes_first_eight);
                        end
                        fail_count++;
                    end
                end
            end
            out_stall <= (hold_count != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Waits until every queued character has been sent and answered.
    task automatic wait_drained();
        while (unsent_chars.size() != 0 || in_valid || expected_escapes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_ASCII_ONLY)
        begin
            ascii_only_shadow = value;
        end
        else if (index == CFG_QUOTE_STYLE)
        begin
            quote_style_shadow = value;
        end
    endtask

    task automatic apply_settings(input logic ascii_mode, input logic single_quote,
                                  input int send_pct, input int recv_pct);
        write_register(CFG_ASCII_ONLY, ascii_mode);
        write_register(CFG_QUOTE_STYLE, single_quote);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic queue_random(input int count);
        @(negedge clk);
        repeat (count) unsent_chars = {unsent_chars, random_char()};
    endtask

    // Stimulus sequence.
    initial
    begin
        logic [20:0] corner_points [$] = '{
            21'h000000, 21'h000008, 21'h000009, 21'h00000A, 21'h00000C, 21'h00000D,
            21'h00001F, 21'h000020, 21'h000022, 21'h000027, 21'h00005C, 21'h00007E,
            21'h00007F, 21'h000080, 21'h0007FF, 21'h00D800, 21'h00DFFF, 21'h00FEFF,
            21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h110000};
        in_item_t item;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Writes to indexes past the register list must leave the settings alone.
        write_register(CFG_SPARE_2, 1'b1);
        write_register(CFG_SPARE_3, 1'b1);

        // Directed corners: markers, spare opcode and the code point boundaries.
        apply_settings(1'b0, 1'b0, 27, 86);
        item = '{opcode: OP_OPEN_QUOTE, code_point: 21'h000000};
        unsent_chars = {unsent_chars, item};
        item = '{opcode: OP_CLOSE_QUOTE, code_point: 21'h1FFFFF};
        unsent_chars = {unsent_chars, item};
        item = '{opcode: OP_SPARE, code_point: 21'h000022};
        unsent_chars = {unsent_chars, item};
        foreach (corner_points[k])
        begin
            item = '{opcode: OP_CODE_POINT, code_point: corner_points[k]};
            unsent_chars = {unsent_chars, item};
        end
        item = '{opcode: OP_CODE_POINT, code_point: 21'h1FFFFF};
        unsent_chars = {unsent_chars, item};
        wait_drained();

        apply_settings(1'b1, 1'b0, 27, 86);
        queue_random(240);
        wait_drained();

        apply_settings(1'b0, 1'b1, 86, 27);
        queue_random(240);
        wait_drained();

        apply_settings(1'b1, 1'b1, 86, 27);
        queue_random(240);
        wait_drained();

        // Full rate with a long output hold-off so the input side backs up.
        apply_settings(1'b0, 1'b0, 0, 0);
        queue_random(120);
        hold_request = 1'b1;
        while (hold_count == 0)
        begin
            @(negedge clk);
        end
        hold_request = 1'b0;
        wait_drained();
        queue_random(120);
        wait_drained();

        write_register(CFG_SPARE_2, 1'b0);
        apply_settings(1'b1, 1'b0, 0, 0);
        queue_random(400);
        wait_drained();

        if (fail_count == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Run limit.
    initial
    begin
        #400000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sle_pkg.sv
hdl/string_literal_escaper_unit.sv
verif/tb_top.sv
